>>> hdl/amr_cm_pkg.sv
// package for the refined cell mask block: item types, operation codes,
// register indexes and reset values. no dependencies.
package amr_cm_pkg;

    localparam int MAX_CELLS_PER_AXIS = 16;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int COORD_W    = 32;
    localparam int CELLS_W    = 5;
    localparam int LEVEL_W    = 6;
    localparam int CELL_NUM_W = 12;
    localparam int COUNT_W    = 13;

    // operation codes
    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_REFINE = 2'd1;
    localparam logic [1:0] OP_WINDOW = 2'd2;
    localparam logic [1:0] OP_QUERY  = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_LO_X    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_LO_Y    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_LO_Z    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_WIDTH   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CELLS_X      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CELLS_Y      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_CELLS_Z      = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_COARSE_LEVEL = 3'd7;

    localparam logic [COORD_W-1:0] RST_CELL_WIDTH = 32'd268435456;
    localparam logic [CELLS_W-1:0] RST_CELLS      = 5'd16;

    typedef struct packed {
        logic [1:0]            operation;
        logic [COORD_W-1:0]    box_lo_x;
        logic [COORD_W-1:0]    box_lo_y;
        logic [COORD_W-1:0]    box_lo_z;
        logic [COORD_W-1:0]    box_hi_x;
        logic [COORD_W-1:0]    box_hi_y;
        logic [COORD_W-1:0]    box_hi_z;
        logic [LEVEL_W-1:0]    box_level;
        logic [CELL_NUM_W-1:0] cell_number;
    } t_in_item;

    typedef struct packed {
        logic [COUNT_W-1:0] newly_marked;
        logic               cell_marked;
        logic               box_skipped;
    } t_out_item;

endpackage

>>> hdl/amr_refined_cell_mask.sv
// Refined cell mask: one mask bit per coarse cell, kept in a single-port-write,
// one-read memory of MAX_CELLS_PER_AXIS cubed bits. A box or window item walks
// the cells one per cycle through a shared edge-compare unit and a read-modify-
// write pipe on the memory; it goes straight to the result when an axis has
// no cells or a refine box is skipped. A clear item writes one mask entry per
// cycle over the whole memory; a query reports the mask bit of one cell.
// After reset the same clearing pass runs over all MAX_CELLS_PER_AXIS**3 entries
// (4096 at the default) with the input stalled; configuration writes are
// taken at any time. One item is worked on at a time, and the next item may
// be taken while a result waits in the output register.
// depends on amr_cm_pkg

module amr_refined_cell_mask #(
    parameter int MAX_CELLS_PER_AXIS = amr_cm_pkg::MAX_CELLS_PER_AXIS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  amr_cm_pkg::t_in_item                i_in,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output amr_cm_pkg::t_out_item               o_out,
    input  logic                                i_cfg_we,
    input  logic [amr_cm_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [amr_cm_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int DEPTH = MAX_CELLS_PER_AXIS * MAX_CELLS_PER_AXIS * MAX_CELLS_PER_AXIS;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(MAX_CELLS_PER_AXIS + 1);
    localparam int EW    = amr_cm_pkg::COORD_W + CW;
    localparam int CNT_W = amr_cm_pkg::COUNT_W;

    typedef enum logic [7:0] {
        S_CLEAR = 8'b00000001,
        S_IDLE  = 8'b00000010,
        S_SWEEP = 8'b00000100,
        S_DRAIN = 8'b00001000,
        S_QRY0  = 8'b00010000,
        S_QRY1  = 8'b00100000,
        S_QRY2  = 8'b01000000,
        S_DONE  = 8'b10000000
    } t_state;

    // configuration
    logic [amr_cm_pkg::COORD_W-1:0] r_lo_x, r_lo_y, r_lo_z, r_width;
    logic [amr_cm_pkg::CELLS_W-1:0] r_cells_x, r_cells_y, r_cells_z;
    logic [amr_cm_pkg::LEVEL_W-1:0] r_level;

    t_state          r_state, n_state;
    logic [AW-1:0]   r_addr;
    logic            r_clr_op;
    logic [1:0]      r_op;
    logic [EW-1:0]   r_bl_x, r_bl_y, r_bl_z, r_bh_x, r_bh_y, r_bh_z;
    logic [EW-1:0]   r_x0h, r_y0h;
    logic [EW-1:0]   r_xl, r_xh, r_yl, r_yh, r_zl, r_zh;
    logic [CW-1:0]   r_i, r_j, r_k;
    logic [amr_cm_pkg::CELL_NUM_W-1:0] r_cn;
    logic [2*CW-1:0] r_nxy;
    logic            r_qhit;
    logic            r_p_valid, r_p_hit;
    logic [AW-1:0]   r_p_addr;
    logic [CNT_W-1:0] r_count;
    logic            r_marked, r_skipped;
    logic            r_out_valid;
    amr_cm_pkg::t_out_item r_out;

    logic            r_mem [DEPTH];
    logic            r_rd_data;

    logic [CW-1:0]   nx, ny, nz;
    logic [3*CW-1:0] total;
    logic            in_accept, out_free, all_ovl, hit, any_empty, level_ok;
    logic            last_x, last_y, last_z;
    logic            mem_we, mem_wd;
    logic [AW-1:0]   mem_wa, rd_addr;
    logic [EW-1:0]   lo_x_e, lo_y_e, lo_z_e, w_e;

    // counts above the maximum act as the maximum
    always_comb begin
        nx = (32'(r_cells_x) > 32'(MAX_CELLS_PER_AXIS)) ? CW'(MAX_CELLS_PER_AXIS)
                                                        : CW'(r_cells_x);
        ny = (32'(r_cells_y) > 32'(MAX_CELLS_PER_AXIS)) ? CW'(MAX_CELLS_PER_AXIS)
                                                        : CW'(r_cells_y);
        nz = (32'(r_cells_z) > 32'(MAX_CELLS_PER_AXIS)) ? CW'(MAX_CELLS_PER_AXIS)
                                                        : CW'(r_cells_z);
    end

    assign lo_x_e = EW'(r_lo_x);
    assign lo_y_e = EW'(r_lo_y);
    assign lo_z_e = EW'(r_lo_z);
    assign w_e    = EW'(r_width);

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_accept   = i_in_valid && (r_state == S_IDLE);
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign any_empty = (nx == '0) || (ny == '0) || (nz == '0);
    // level compare at 7 bits so a coarse level of 63 never matches
    assign level_ok  = ({1'b0, i_in.box_level} == (7'(r_level) + 7'd1));

    // shared edge-compare unit: open-interval overlap on all three axes,
    // and a window hit is the complement (outside on some axis)
    assign all_ovl = (r_bl_x < r_xh) && (r_bh_x > r_xl)
                  && (r_bl_y < r_yh) && (r_bh_y > r_yl)
                  && (r_bl_z < r_zh) && (r_bh_z > r_zl);
    assign hit     = (r_op == amr_cm_pkg::OP_REFINE) ? all_ovl : !all_ovl;

    assign last_x = (r_i == nx - CW'(1));
    assign last_y = (r_j == ny - CW'(1));
    assign last_z = (r_k == nz - CW'(1));

    assign total = (3*CW)'(r_nxy) * (3*CW)'(nz);

    // memory port selection
    always_comb begin
        mem_we = 1'b0;
        mem_wd = 1'b0;
        mem_wa = r_addr;
        if (r_state == S_CLEAR) begin
            mem_we = 1'b1;
        end else if (r_p_valid && r_p_hit && !r_rd_data) begin
            mem_we = 1'b1;
            mem_wd = 1'b1;
            mem_wa = r_p_addr;
        end
        rd_addr = (r_state == S_QRY1) ? AW'(r_cn) : r_addr;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_addr == AW'(DEPTH - 1)) begin
                    n_state = r_clr_op ? S_DONE : S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_accept) begin
                    case (i_in.operation)
                        amr_cm_pkg::OP_CLEAR:  n_state = S_CLEAR;
                        amr_cm_pkg::OP_REFINE: n_state = (level_ok && !any_empty) ? S_SWEEP
                                                                                 : S_DONE;
                        amr_cm_pkg::OP_WINDOW: n_state = any_empty ? S_DONE : S_SWEEP;
                        default:               n_state = S_QRY0;
                    endcase
                end
            end
            S_SWEEP: begin
                if (last_x && last_y && last_z) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: n_state = S_DONE;
            S_QRY0:  n_state = S_QRY1;
            S_QRY1:  n_state = S_QRY2;
            S_QRY2:  n_state = S_DONE;
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_addr      <= '0;
            r_clr_op    <= 1'b0;
            r_p_valid   <= 1'b0;
            r_out_valid <= 1'b0;
            r_lo_x      <= '0;
            r_lo_y      <= '0;
            r_lo_z      <= '0;
            r_width     <= amr_cm_pkg::RST_CELL_WIDTH;
            r_cells_x   <= amr_cm_pkg::RST_CELLS;
            r_cells_y   <= amr_cm_pkg::RST_CELLS;
            r_cells_z   <= amr_cm_pkg::RST_CELLS;
            r_level     <= '0;
        end else begin
            r_state   <= n_state;
            r_p_valid <= (r_state == S_SWEEP);

            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    amr_cm_pkg::CFG_GRID_LO_X:    r_lo_x    <= i_cfg_data;
                    amr_cm_pkg::CFG_GRID_LO_Y:    r_lo_y    <= i_cfg_data;
                    amr_cm_pkg::CFG_GRID_LO_Z:    r_lo_z    <= i_cfg_data;
                    amr_cm_pkg::CFG_CELL_WIDTH:   r_width   <= i_cfg_data;
                    amr_cm_pkg::CFG_CELLS_X:      r_cells_x <= i_cfg_data[amr_cm_pkg::CELLS_W-1:0];
                    amr_cm_pkg::CFG_CELLS_Y:      r_cells_y <= i_cfg_data[amr_cm_pkg::CELLS_W-1:0];
                    amr_cm_pkg::CFG_CELLS_Z:      r_cells_z <= i_cfg_data[amr_cm_pkg::CELLS_W-1:0];
                    amr_cm_pkg::CFG_COARSE_LEVEL: r_level   <= i_cfg_data[amr_cm_pkg::LEVEL_W-1:0];
                    default: ;
                endcase
            end

            if (in_accept) begin
                r_addr   <= '0;
                r_clr_op <= (i_in.operation == amr_cm_pkg::OP_CLEAR);
            end else if (r_state == S_CLEAR || r_state == S_SWEEP) begin
                r_addr <= r_addr + AW'(1);
            end

            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_p_hit  <= hit;
        r_p_addr <= r_addr;

        if (in_accept) begin
            r_op      <= i_in.operation;
            r_cn      <= i_in.cell_number;
            r_bl_x    <= EW'(i_in.box_lo_x);
            r_bl_y    <= EW'(i_in.box_lo_y);
            r_bl_z    <= EW'(i_in.box_lo_z);
            r_bh_x    <= EW'(i_in.box_hi_x);
            r_bh_y    <= EW'(i_in.box_hi_y);
            r_bh_z    <= EW'(i_in.box_hi_z);
            r_count   <= '0;
            r_marked  <= 1'b0;
            r_skipped <= (i_in.operation == amr_cm_pkg::OP_REFINE) && !level_ok;
            r_i       <= '0;
            r_j       <= '0;
            r_k       <= '0;
            r_xl      <= lo_x_e;
            r_yl      <= lo_y_e;
            r_zl      <= lo_z_e;
            r_xh      <= lo_x_e + w_e;
            r_yh      <= lo_y_e + w_e;
            r_zh      <= lo_z_e + w_e;
            r_x0h     <= lo_x_e + w_e;
            r_y0h     <= lo_y_e + w_e;
        end else if (r_state == S_SWEEP) begin
            // walk x fastest, then y, then z; edges advance by one cell width
            if (!last_x) begin
                r_i  <= r_i + CW'(1);
                r_xl <= r_xh;
                r_xh <= r_xh + w_e;
            end else begin
                r_i  <= '0;
                r_xl <= lo_x_e;
                r_xh <= r_x0h;
                if (!last_y) begin
                    r_j  <= r_j + CW'(1);
                    r_yl <= r_yh;
                    r_yh <= r_yh + w_e;
                end else begin
                    r_j  <= '0;
                    r_yl <= lo_y_e;
                    r_yh <= r_y0h;
                    r_k  <= r_k + CW'(1);
                    r_zl <= r_zh;
                    r_zh <= r_zh + w_e;
                end
            end
        end

        if (r_p_valid && r_p_hit && !r_rd_data) begin
            r_count <= r_count + CNT_W'(1);
        end

        if (r_state == S_QRY0) begin
            r_nxy <= (2*CW)'(nx) * (2*CW)'(ny);
        end
        if (r_state == S_QRY1) begin
            r_qhit <= (32'(r_cn) < 32'(total));
        end
        if (r_state == S_QRY2) begin
            r_marked <= r_qhit && r_rd_data;
        end

        if (r_state == S_DONE && out_free) begin
            r_out.newly_marked <= r_count;
            r_out.cell_marked  <= r_marked;
            r_out.box_skipped  <= r_skipped;
        end
    end

    // read-modify-write addresses climb by one cell each cycle
    a_rmw_addr_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_p_valid && $past(r_p_valid)) |-> (r_p_addr == $past(r_p_addr) + AW'(1)))
        else $error("mask update address did not advance by one");

    // no mark write lands during a clearing pass
    a_no_mark_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !r_p_valid)
        else $error("mark update overlaps clearing pass");

    // a result is only loaded out of the done state
    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !$past(o_out_valid)) |-> ($past(r_state) == S_DONE))
        else $error("result appeared outside the done state");

    // cell counters stay inside the grid while sweeping
    a_sweep_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWEEP) |-> ((r_i < nx) && (r_j < ny) && (r_k < nz)))
        else $error("sweep counter left the grid");

    // a refine box that was skipped never marks a cell
    a_skip_no_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_skipped) |-> (r_count == '0))
        else $error("skipped refine box reported marks");

endmodule
